### rtl/core/positional_array_list_defines.svh
// Assertion macros used by the positional array list back end.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pal_pkg.sv
// Types and codes shared by the positional array list modules.
`timescale 1ns / 1ps
package pal_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 7;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_SEARCH   = 2'd2,
    REQ_TRAVERSE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    CMD_ERR,
    CMD_INS,
    CMD_DEL,
    CMD_SRCH,
    CMD_TRAV
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    status_e           status;  // only meaningful for CMD_ERR
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  cnt;     // list length before this command
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } bk_state_e;

endpackage

### rtl/core/pal_front.sv
// Front end: accepts request beats, checks them against the running count.
`timescale 1ns / 1ps
module pal_front #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [1:0]                   req_type_i,
  input  logic [pal_pkg::VAL_W-1:0]    item_value_i,
  input  logic [pal_pkg::POS_W-1:0]    list_position_i,
  input  logic                         q_full_i,
  output logic                         busy,
  output logic                         push_o,
  output pal_pkg::cmd_t                cmd_o
);

  // Count as it will stand once every queued command has run.
  logic [pal_pkg::POS_W-1:0] count_q, count_d;
  logic                      accept;

  assign busy   = q_full_i;
  assign accept = start && !q_full_i;
  assign push_o = accept;

  always_comb begin
    cmd_o.op     = pal_pkg::CMD_ERR;
    cmd_o.status = pal_pkg::ST_OK;
    cmd_o.value  = item_value_i;
    cmd_o.pos    = list_position_i;
    cmd_o.cnt    = count_q;
    count_d      = count_q;
    unique case (pal_pkg::req_e'(req_type_i))
      pal_pkg::REQ_INSERT: begin
        if (list_position_i == '0 || list_position_i > count_q + 7'd1) begin
          cmd_o.status = pal_pkg::ST_BADPOS;
        end else if (count_q == 7'(CAPACITY)) begin
          cmd_o.status = pal_pkg::ST_FULL;
        end else begin
          cmd_o.op = pal_pkg::CMD_INS;
          count_d  = count_q + 7'd1;
        end
      end
      pal_pkg::REQ_DELETE: begin
        if (count_q == '0) begin
          cmd_o.status = pal_pkg::ST_EMPTY;
        end else if (list_position_i == '0 || list_position_i > count_q) begin
          cmd_o.status = pal_pkg::ST_BADPOS;
        end else begin
          cmd_o.op = pal_pkg::CMD_DEL;
          count_d  = count_q - 7'd1;
        end
      end
      pal_pkg::REQ_SEARCH: begin
        if (count_q == '0) begin
          cmd_o.status = pal_pkg::ST_NOTFOUND;
        end else begin
          cmd_o.op = pal_pkg::CMD_SRCH;
        end
      end
      pal_pkg::REQ_TRAVERSE: begin
        if (count_q == '0) begin
          cmd_o.status = pal_pkg::ST_EMPTY;
        end else begin
          cmd_o.op = pal_pkg::CMD_TRAV;
        end
      end
      default: cmd_o.status = pal_pkg::ST_BADPOS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

endmodule

### rtl/core/pal_cmdq.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module pal_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pal_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output pal_pkg::cmd_t head_o
);

  pal_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

### rtl/core/pal_back.sv
// Back end: list memory and the shift/scan sequencer that runs commands.
`timescale 1ns / 1ps
`include "positional_array_list_defines.svh"
module pal_back #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  pal_pkg::cmd_t                     q_head_i,
  output logic                              pop_o,
  output logic                              strobe_o,
  output logic [2:0]                        status_o,
  output logic signed [pal_pkg::VAL_W-1:0]  out_value_o,
  output logic [pal_pkg::POS_W-1:0]         out_position_o,
  output logic                              last_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  pal_pkg::bk_state_e state_q, state_d;
  pal_pkg::cmd_t      cur_q, cur_d;

  logic [pal_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [pal_pkg::VAL_W-1:0] rdata_q;
  logic [pal_pkg::VAL_W-1:0] rem_q, rem_d;
  logic                      mem_we;
  logic [IW-1:0]             mem_wa, mem_ra;
  logic [pal_pkg::VAL_W-1:0] mem_wd;

  // Read pipeline: rd_idx is the address being read now, pidx the index
  // whose data sits in rdata_q when pv is set.
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          rd_more_q, rd_more_d;
  logic          pv_q, pv_d;
  logic          first_q, first_d;

  logic [IW-1:0] pos_idx, cnt_idx, end_idx, head_start;
  logic          append, hit, last_pidx;

  logic                      res_vld;
  pal_pkg::status_e          res_status;
  logic [pal_pkg::VAL_W-1:0] res_value;
  logic [pal_pkg::POS_W-1:0] res_pos;
  logic                      res_last;

  assign pos_idx   = IW'(cur_q.pos - 7'd1);
  assign cnt_idx   = IW'(cur_q.cnt - 7'd1);
  assign end_idx   = (cur_q.op == pal_pkg::CMD_INS) ? pos_idx : cnt_idx;
  assign hit       = (rdata_q == cur_q.value);
  assign last_pidx = (pidx_q == cnt_idx);
  assign append    = (q_head_i.op == pal_pkg::CMD_INS) &&
                     (q_head_i.pos == q_head_i.cnt + 7'd1);

  always_comb begin
    unique case (q_head_i.op)
      pal_pkg::CMD_INS: head_start = IW'(q_head_i.cnt - 7'd1);
      pal_pkg::CMD_DEL: head_start = IW'(q_head_i.pos - 7'd1);
      default:          head_start = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pal_pkg::BK_IDLE: begin
        if (!q_empty_i && q_head_i.op != pal_pkg::CMD_ERR) begin
          state_d = append ? pal_pkg::BK_FIN : pal_pkg::BK_RUN;
        end
      end
      pal_pkg::BK_RUN: begin
        unique case (cur_q.op)
          pal_pkg::CMD_SRCH: if (pv_q && (hit || last_pidx)) state_d = pal_pkg::BK_IDLE;
          pal_pkg::CMD_TRAV: if (pv_q && last_pidx) state_d = pal_pkg::BK_IDLE;
          default:           if (pv_q && !rd_more_q) state_d = pal_pkg::BK_FIN;
        endcase
      end
      pal_pkg::BK_FIN: state_d = pal_pkg::BK_IDLE;
      default:         state_d = pal_pkg::BK_IDLE;
    endcase
  end

  // Datapath and results
  always_comb begin
    cur_d      = cur_q;
    rem_d      = rem_q;
    rd_idx_d   = rd_idx_q;
    pidx_d     = pidx_q;
    rd_more_d  = rd_more_q;
    pv_d       = pv_q;
    first_d    = first_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = rdata_q;
    mem_ra     = rd_idx_q;
    res_vld    = 1'b0;
    res_status = pal_pkg::ST_OK;
    res_value  = '0;
    res_pos    = '0;
    res_last   = 1'b1;
    unique case (state_q)
      pal_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (q_head_i.op == pal_pkg::CMD_ERR) begin
            res_vld    = 1'b1;
            res_status = q_head_i.status;
          end else begin
            cur_d     = q_head_i;
            rd_idx_d  = head_start;
            rd_more_d = 1'b1;
            pv_d      = 1'b0;
            first_d   = 1'b1;
          end
        end
      end
      pal_pkg::BK_RUN: begin
        if (rd_more_q) begin
          pv_d      = 1'b1;
          pidx_d    = rd_idx_q;
          first_d   = !pv_q;
          rd_more_d = (rd_idx_q != end_idx);
          rd_idx_d  = (cur_q.op == pal_pkg::CMD_INS) ? rd_idx_q - IW'(1)
                                                      : rd_idx_q + IW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          unique case (cur_q.op)
            pal_pkg::CMD_INS: begin
              mem_we = 1'b1;
              mem_wa = pidx_q + IW'(1);
            end
            pal_pkg::CMD_DEL: begin
              if (first_q) begin
                rem_d = rdata_q;
              end else begin
                mem_we = 1'b1;
                mem_wa = pidx_q - IW'(1);
              end
            end
            pal_pkg::CMD_SRCH: begin
              if (hit) begin
                res_vld = 1'b1;
                res_pos = 7'(pidx_q) + 7'd1;
              end else if (last_pidx) begin
                res_vld    = 1'b1;
                res_status = pal_pkg::ST_NOTFOUND;
              end
            end
            pal_pkg::CMD_TRAV: begin
              res_vld   = 1'b1;
              res_value = rdata_q;
              res_pos   = 7'(pidx_q) + 7'd1;
              res_last  = last_pidx;
            end
            default: ;
          endcase
        end
      end
      pal_pkg::BK_FIN: begin
        res_vld = 1'b1;
        res_pos = cur_q.pos;
        if (cur_q.op == pal_pkg::CMD_INS) begin
          mem_we = 1'b1;
          mem_wa = pos_idx;
          mem_wd = cur_q.value;
        end else begin
          res_value = rem_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    cur_q          <= cur_d;
    rem_q          <= rem_d;
    rd_idx_q       <= rd_idx_d;
    pidx_q         <= pidx_d;
    first_q        <= first_d;
    status_o       <= res_status;
    out_value_o    <= res_value;
    out_position_o <= res_pos;
    last_o         <= res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pal_pkg::BK_IDLE;
      rd_more_q <= 1'b0;
      pv_q      <= 1'b0;
      strobe_o  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_more_q <= rd_more_d;
      pv_q      <= pv_d;
      strobe_o  <= res_vld;
    end
  end

  `PAL_ASSERT_NOW(a_no_write_idle, mem_we, state_q != pal_pkg::BK_IDLE, "memory written while idle")
  `PAL_ASSERT_NOW(a_run_result_scan, res_vld && state_q == pal_pkg::BK_RUN, cur_q.op == pal_pkg::CMD_SRCH || cur_q.op == pal_pkg::CMD_TRAV, "shift command emitted mid-run")
  `PAL_ASSERT_NEXT(a_fin_one_cycle, state_q == pal_pkg::BK_FIN, state_q == pal_pkg::BK_IDLE && strobe_o, "finish did not close the command")

endmodule

### rtl/core/positional_array_list.sv
// Top level of the positional array list: front, command queue, back.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values.
//
// Request channel: a beat is taken on a rising edge with start high and busy
// low. req_type_i selects insert, delete, search or traverse; item_value_i
// and the 1-based list_position_i go with it. busy rises only when the
// two-entry command queue between front and back is full.
// Result channel: each result beat is held one cycle, flagged by strobe_o;
// the receiver cannot stall it. last_o marks the final beat of a request.
// Work per request, from leaving the queue to its final beat (n entries held):
//   error result                  one result beat
//   insert at position p          shift entries p..n up one place, then write
//                                 the value (append: write only)
//   delete at position p          save entry p, shift entries above it down
//   search                        scan from position 1 to a hit or to entry n
//   traverse                      one beat per entry, one beat per cycle
// The list memory has one read port and one write port; each shift step
// moves one entry through the registered read port.
// Up to two requests wait in the queue while one runs.
// Reset empties the list (count zero) and the queue; memory contents are
// not cleared and need no clearing pass, since only written entries are read.
module positional_array_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type_i,
  input  logic signed [pal_pkg::VAL_W-1:0]  item_value_i,
  input  logic [pal_pkg::POS_W-1:0]         list_position_i,
  output logic                              strobe_o,
  output logic [2:0]                        status_o,
  output logic signed [pal_pkg::VAL_W-1:0]  out_value_o,
  output logic [pal_pkg::POS_W-1:0]         out_position_o,
  output logic                              last_o
);

  logic          push, pop, q_full, q_empty;
  pal_pkg::cmd_t push_cmd, head_cmd;

  // Front classifies against the count as it will be after queued work.
  pal_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .req_type_i      (req_type_i),
    .item_value_i    (item_value_i),
    .list_position_i (list_position_i),
    .q_full_i        (q_full),
    .busy            (busy),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  pal_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // Back owns the list memory and emits every result beat.
  pal_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (head_cmd),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_position_o (out_position_o),
    .last_o         (last_o)
  );

endmodule
